### rtl/core/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types and constants for the streaming SHA-256 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // command passed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_LAST = 2'd1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ABSORB = 3'd0,
        ST_ROUNDS = 3'd1,
        ST_FOLD   = 3'd2,
        ST_PAD    = 3'd3,
        ST_EMIT   = 3'd4
    } back_state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

### rtl/core/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  sha_pkg::sha_in_t     s_data,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output sha_pkg::cmd_t        cmd_data
);
    import sha_pkg::*;

    cmd_t             queue_mem [QUEUE_DEPTH];
    logic [QPTR_W:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W:0]  rd_ptr_reg, rd_ptr_next;
    logic             push, pop;
    cmd_t             new_cmd;

    // classify the incoming item
    always_comb begin
        new_cmd.kind = s_data.func ? CMD_LAST : CMD_BYTE;
        new_cmd.data = s_data.data_byte;
    end

    assign s_ready   = (wr_ptr_reg - rd_ptr_reg) != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign cmd_valid = wr_ptr_reg != rd_ptr_reg;
    assign cmd_data  = queue_mem[rd_ptr_reg[QPTR_W-1:0]];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg[QPTR_W-1:0]] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Block buffer, padding sequencer, one-round-per-cycle compression and
// digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  sha_pkg::cmd_t        cmd_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output sha_pkg::sha_out_t    m_data
);
    import sha_pkg::*;

    back_state_t  state_reg, state_next;
    word_t        h_reg [8];
    word_t        v_reg [8];
    word_t        w_reg [16];
    logic [5:0]   fill_reg;
    logic [5:0]   round_reg;
    logic [63:0]  bits_reg;
    logic [63:0]  pad_bits_reg;
    logic         finishing_reg;
    logic         len_sent_reg;
    logic         len_blk_reg;
    logic [2:0]   emit_idx_reg;
    logic         out_valid_reg;
    sha_out_t     out_data_reg;

    logic         byte_in;
    logic [7:0]   byte_val;
    logic         take_cmd;
    word_t        w_cur, w_new, s0, s1, t1, t2, big0, big1, ch, maj;
    logic [7:0]   pad_byte;

    // index of the digest word loaded next
    function automatic logic [2:0] next_idx();
        next_idx = out_valid_reg ? emit_idx_reg + 3'd1 : emit_idx_reg;
    endfunction

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // padding byte at the current fill position, length only in its block
    always_comb begin
        if (len_blk_reg && fill_reg >= 6'd56) begin
            pad_byte = pad_bits_reg[63 - 8*(fill_reg[2:0]) -: 8];
        end else begin
            pad_byte = '0;
        end
    end

    // schedule and round logic
    always_comb begin
        w_cur = w_reg[0];
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        big1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + ROUND_K[round_reg] + w_cur;
        big0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        take_cmd   = 1'b0;
        byte_in    = 1'b0;
        byte_val   = cmd_data.data;
        unique case (state_reg)
            ST_ABSORB: begin
                if (cmd_valid) begin
                    take_cmd = 1'b1;
                    if (cmd_data.kind == CMD_BYTE) begin
                        byte_in = 1'b1;
                        if (fill_reg == 6'd63) begin
                            state_next = ST_ROUNDS;
                        end
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                byte_in  = 1'b1;
                byte_val = finishing_reg ? pad_byte : PAD_BYTE;
                if (fill_reg == 6'd63) begin
                    state_next = ST_ROUNDS;
                end
            end
            ST_ROUNDS: begin
                if (round_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (finishing_reg && len_sent_reg) begin
                    state_next = ST_EMIT;
                end else if (finishing_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_ABSORB;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    if (emit_idx_reg == 3'd7 && out_valid_reg) begin
                        state_next = ST_ABSORB;
                    end
                end
            end
            default: state_next = ST_ABSORB;
        endcase
    end

    assign cmd_ready = (state_reg == ST_ABSORB);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ABSORB;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath and control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            round_reg     <= '0;
            bits_reg      <= '0;
            finishing_reg <= 1'b0;
            len_sent_reg  <= 1'b0;
            len_blk_reg   <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_HASH[i];
            end
        end else begin
            unique case (state_reg)
                ST_ABSORB: begin
                    if (take_cmd && cmd_data.kind == CMD_LAST) begin
                        pad_bits_reg  <= bits_reg;
                        finishing_reg <= 1'b0;
                        len_sent_reg  <= 1'b0;
                        // the length fits behind the 0x80 byte only up to byte 55
                        len_blk_reg   <= (fill_reg <= 6'd55);
                    end
                    if (take_cmd && cmd_data.kind == CMD_BYTE) begin
                        bits_reg <= bits_reg + 64'd8;
                    end
                end
                ST_PAD: begin
                    finishing_reg <= 1'b1;
                    if (fill_reg == 6'd63) begin
                        // length went out with this block, or goes with the next
                        len_sent_reg <= len_blk_reg;
                        len_blk_reg  <= 1'b1;
                    end
                end
                ST_ROUNDS: begin
                    round_reg <= round_reg + 6'd1;
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    emit_idx_reg <= '0;
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        if (out_valid_reg && emit_idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= INIT_HASH[i];
                            end
                            out_valid_reg <= 1'b0;
                            bits_reg      <= '0;
                            fill_reg      <= '0;
                            finishing_reg <= 1'b0;
                            len_sent_reg  <= 1'b0;
                        end else begin
                            out_valid_reg <= 1'b1;
                            out_data_reg.digest_word <= h_reg[next_idx()];
                            out_data_reg.word_index  <= next_idx();
                            out_data_reg.last_word   <= (next_idx() == 3'd7);
                            if (out_valid_reg) begin
                                emit_idx_reg <= emit_idx_reg + 3'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            // byte into the block buffer, shifted in as schedule words
            if (byte_in) begin
                w_reg[fill_reg[5:2]] <= {w_reg[fill_reg[5:2]][23:0], byte_val};
                fill_reg <= fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= h_reg[i];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/sha256_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_top
// Streaming SHA-256 engine: byte items in, eight digest words out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                             | handshake
//  s_      | in  | func, data_byte                     | s_valid / s_ready
//  m_      | out | digest_word, word_index, last_word  | m_valid / m_ready
//
//  data bytes fill the block buffer; the 64th byte of a block starts the
//  one-round-per-cycle compression loop, followed by the fold.
//  a finish item pads the message, running one or two compressions,
//  then loads and outputs eight digest words, each held by m_ready.
//  a four-entry command queue keeps taking items while the back end
//  compresses, until it is full. reset is synchronous, active low.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hash_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  sha_pkg::sha_in_t   s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sha_pkg::sha_out_t  m_data
);
    import sha_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd_data;

    sha_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
    );

    sha_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // helpers for the output checks
    logic last_ok, word_taken;
    assign last_ok    = m_data.last_word == (m_data.word_index == 3'd7);
    assign word_taken = m_valid && m_ready && !m_data.last_word;

    `ASSERT_CLK(a_last_idx, aclk, aresetn, !m_valid || last_ok, "last flag mismatch")
    `ASSERT_CLK(a_idx_step, aclk, aresetn, word_taken |=> m_valid, "digest words not contiguous")
    `ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_valid, "output valid after reset")

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming SHA-256 engine: random and directed
// byte messages are hashed by an in-bench predictor and the digest words
// returned by the engine are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sha_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sha_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sha_out_t m_data;

    sha256_stream_hash_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    word_t       hash_state [8];
    logic [7:0]  blk_buf [64];
    int unsigned blk_fill;
    logic [63:0] bit_len;

    sha_in_t  pending_items [$];
    sha_out_t digest_fifo [$];
    int       hold_slots [$];   // -1 means wait until all digests are drained
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       stim_done = 1'b0;

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_block();
        word_t w [64];
        word_t v [8];
        word_t t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        blk_buf[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            hash_block();
            blk_fill = 0;
        end
    endtask

    function automatic void restart_hash();
        hash_state = INIT_HASH;
        blk_fill = 0;
        bit_len = '0;
    endfunction

    // predictor update for one accepted item; a finish item queues the expected digest words
    task automatic predict_digest(sha_in_t it);
        logic [63:0] len;
        sha_out_t    r;
        if (!it.func) begin
            bit_len += 64'd8;
            absorb_byte(it.data_byte);
        end else begin
            len = bit_len;
            absorb_byte(PAD_BYTE);
            while (blk_fill != 56) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                r.digest_word = hash_state[i];
                r.word_index  = 3'(i);
                r.last_word   = (i == 7);
                digest_fifo.push_back(r);
            end
            restart_hash();
        end
    endtask

    function automatic void add_item(logic fn, logic [7:0] b, int hold);
        sha_in_t it;
        it.func = fn;
        it.data_byte = b;
        pending_items.push_back(it);
        hold_slots.push_back(hold);
    endfunction

    function automatic int rand_hold();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void add_message(int len);
        for (int i = 0; i < len; i++) add_item(1'b0, 8'($urandom), rand_hold());
        add_item(1'b1, 8'($urandom), rand_hold());
    endfunction

    // driver
    int send_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_digest(s_data);
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    s_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_items.size() != 0
                             && hold_slots[0] == -1 && digest_fifo.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    send_wait <= (hold_slots[0] < 0) ? 0 : hold_slots[0];
                    void'(hold_slots.pop_front());
                end else begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    int recv_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_fifo.size() == 0) begin
                    $error("unexpected digest word %h", m_data.digest_word);
                    fail_count++;
                end else begin
                    sha_out_t e;
                    e = digest_fifo.pop_front();
                    if (m_data.digest_word !== e.digest_word) begin
                        $error("digest_word exp %h got %h", e.digest_word, m_data.digest_word);
                        fail_count++;
                    end
                    if (m_data.word_index !== e.word_index) begin
                        $error("word_index exp %0d got %0d", e.word_index, m_data.word_index);
                        fail_count++;
                    end
                    if (m_data.last_word !== e.last_word) begin
                        $error("last_word exp %0d got %0d", e.last_word, m_data.last_word);
                        fail_count++;
                    end
                end
            end
            if (m_ready && !m_valid) begin
                // keep ready up while idle
            end else if (m_valid && m_ready) begin
                recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
                m_ready <= (recv_wait == 0);
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= (recv_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[sha256_stream_hash_top] ERROR");
            $finish;
        end
    end

    initial begin
        restart_hash();
        // empty message, then one with every data bit toggling
        add_item(1'b1, 8'hff, 0);
        add_item(1'b0, 8'h00, 0);
        add_item(1'b0, 8'hff, 0);
        add_item(1'b0, 8'h55, 0);
        add_item(1'b0, 8'haa, 0);
        add_item(1'b1, 8'h00, 0);
        // "abc"
        add_item(1'b0, 8'h61, 0);
        add_item(1'b0, 8'h62, 0);
        add_item(1'b0, 8'h63, 0);
        add_item(1'b1, 8'h00, -1);
        // padding boundaries: 55 (one block), 56 (extra block), 64 (full block)
        add_message(55);
        add_message(56);
        add_message(64);
        // random messages, mostly short
        while (pending_items.size() < 310) begin
            if ($urandom_range(0, 5) == 0)
                add_message($urandom_range(50, 130));
            else
                add_message($urandom_range(0, 12));
            if ($urandom_range(0, 4) == 0) hold_slots[hold_slots.size() - 1] = -1;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && digest_fifo.size() == 0);
        repeat (400) @(posedge aclk);
        if (fail_count == 0 && digest_fifo.size() == 0)
            $display("[sha256_stream_hash_top] OK");
        else
            $display("[sha256_stream_hash_top] ERROR");
        $finish;
    end
endmodule
